// File: hw/rtl/stc_pkg.sv
// Shared types, token codes and character-class functions for the script
// token classifier. No dependencies.
package stc_pkg;

    // Request payloads
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [7:0] token_code;
        logic [7:0] token_length;
        logic       last_of_run;
    } t_out;

    // Results caused by one input byte, packed first to second
    typedef struct packed {
        logic [1:0] count;
        t_out       first;
        t_out       second;
    } t_lex_out;

    // First eight label characters, entry 0 is the first character
    typedef logic [7:0][7:0] t_prefix;

    // What a byte does when it starts a fresh token
    typedef struct packed {
        logic       emit;
        logic [7:0] code;
        logic [7:0] len;
        logic       open_label;
        logic       open_math;
    } t_start;

    localparam logic [7:0] CODE_STRING   = 8'd1;
    localparam logic [7:0] CODE_NUMBER   = 8'd2;
    localparam logic [7:0] CODE_LABEL    = 8'd3;
    localparam logic [7:0] CODE_KW_FIRST = 8'd204;
    localparam logic [7:0] CODE_EQ_EQ    = 8'd224;
    localparam logic [7:0] CODE_EQ       = 8'd242;
    localparam logic [7:0] CODE_UNDEF    = 8'd255;
    localparam logic [7:0] ASCII_TOP     = 8'd127;
    localparam logic [7:0] PREFIX_LEN    = 8'd8;

    localparam int KW_NUM = 15;

    // Keywords, right aligned: the last character sits in the low byte
    localparam logic [63:0] KW_TEXT [KW_NUM] = '{
        64'("exit"), 64'("catch"), 64'("try"), 64'("while"), 64'("do"),
        64'("for"), 64'("else"), 64'("if"), 64'("var"), 64'("local"),
        64'("global"), 64'("function"), 64'("return"), 64'("continue"),
        64'("break")
    };
    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd4, 4'd5, 4'd3, 4'd5, 4'd2, 4'd3, 4'd4, 4'd2,
        4'd3, 4'd5, 4'd6, 4'd8, 4'd6, 4'd8, 4'd5
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_name_head(input logic [7:0] c);
        return c == "_" || c == "$" || is_alpha(c);
    endfunction

    function automatic logic is_math(input logic [7:0] c);
        return c == "=" || c == "+" || c == "-" || c == "*" || c == "/" ||
               c == "%" || c == "&" || c == "|" || c == "^" || c == "!" ||
               c == "<" || c == ">";
    endfunction

    // Punctuation code, zero when the byte is not punctuation
    function automatic logic [7:0] punct_code(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            ".":     r = 8'd246;
            ";":     r = 8'd247;
            ",":     r = 8'd248;
            "]":     r = 8'd249;
            ")":     r = 8'd250;
            "}":     r = 8'd251;
            "[":     r = 8'd252;
            "(":     r = 8'd253;
            "{":     r = 8'd254;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] math_single(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            ">":     r = 8'd219;
            "<":     r = 8'd220;
            "!":     r = 8'd225;
            "^":     r = 8'd228;
            "|":     r = 8'd229;
            "&":     r = 8'd230;
            "%":     r = 8'd231;
            "/":     r = 8'd238;
            "*":     r = 8'd239;
            "-":     r = 8'd240;
            "+":     r = 8'd241;
            "=":     r = CODE_EQ;
            default: r = CODE_UNDEF;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] math_pair(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = CODE_UNDEF;
        if (b == "=") begin
            case (a)
                ">":     r = 8'd221;
                "<":     r = 8'd222;
                "!":     r = 8'd223;
                "=":     r = CODE_EQ_EQ;
                "/":     r = 8'd234;
                "*":     r = 8'd235;
                "-":     r = 8'd236;
                "+":     r = 8'd237;
                default: r = CODE_UNDEF;
            endcase
        end else if (a == b) begin
            case (a)
                "|":     r = 8'd226;
                "&":     r = 8'd227;
                "-":     r = 8'd232;
                "+":     r = 8'd233;
                default: r = CODE_UNDEF;
            endcase
        end
        return r;
    endfunction

    // Keyword lookup; fits is low for labels longer than the prefix
    function automatic logic [7:0] label_code(input t_prefix pre, input logic [3:0] len,
                                              input logic fits);
        logic [7:0] r;
        logic       same;
        r = CODE_LABEL;
        for (int k = KW_NUM - 1; k >= 0; k--) begin
            same = fits && (len == KW_LEN[k]);
            for (int j = 0; j < 8; j++) begin
                if (4'(j) < KW_LEN[k]) begin
                    same = same && (pre[j] == KW_TEXT[k][8 * (KW_LEN[k] - 4'(j) - 4'd1) +: 8]);
                end
            end
            if (same) begin
                r = CODE_KW_FIRST + 8'(k);
            end
        end
        return r;
    endfunction

    // Result item; code 255 always carries length zero
    function automatic t_out make_out(input logic [7:0] code, input logic [7:0] len);
        t_out r;
        r.token_code   = code;
        r.token_length = (code == CODE_UNDEF) ? 8'd0 : len;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    // Classify a byte that begins a new token
    function automatic t_start start_byte(input logic [7:0] b);
        t_start r;
        r = '0;
        if (b > ASCII_TOP) begin
            r.emit = 1'b1;
            r.code = b;
        end else if (b == "'" || b == "\"") begin
            r.emit = 1'b1;
            r.code = CODE_STRING;
        end else if (is_digit(b)) begin
            r.emit = 1'b1;
            r.code = CODE_NUMBER;
        end else if (is_name_head(b)) begin
            r.open_label = 1'b1;
        end else if (punct_code(b) != 8'd0) begin
            r.emit = 1'b1;
            r.code = punct_code(b);
            r.len  = 8'd1;
        end else if (is_math(b)) begin
            r.open_math = 1'b1;
        end else begin
            r.emit = 1'b1;
            r.code = CODE_UNDEF;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/stc_lexer.sv
// Lexer state and per-byte classification for the script token classifier.
// Depends on stc_pkg.
module stc_lexer #(
    parameter int MAX_NAME_LEN = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  stc_pkg::t_in      i_item,
    output stc_pkg::t_lex_out o_res
);

    localparam int CW = $clog2(MAX_NAME_LEN + 1);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_MATH  = 2'd1,
        MODE_LABEL = 2'd2
    } t_mode;

    t_mode            r_mode, n_mode;
    logic [7:0]       r_pend, n_pend;
    stc_pkg::t_prefix r_pre, n_pre;
    logic [CW-1:0]    r_cnt, n_cnt;

    stc_pkg::t_out    e [3];
    logic [2:0]       ev;
    stc_pkg::t_start  sb;
    logic             sb_use;
    logic [7:0]       b;

    // Next state and up to three candidate results
    always_comb begin
        b      = i_item.text_byte;
        n_mode = r_mode;
        n_pend = r_pend;
        n_pre  = r_pre;
        n_cnt  = r_cnt;
        ev     = '0;
        e[0]   = '0;
        e[1]   = '0;
        e[2]   = '0;
        sb_use = 1'b0;
        sb     = stc_pkg::start_byte(b);

        case (r_mode)
            MODE_LABEL: begin
                if (stc_pkg::is_name_head(b) || stc_pkg::is_digit(b)) begin
                    if (r_cnt < CW'(stc_pkg::PREFIX_LEN)) begin
                        n_pre[r_cnt[2:0]] = b;
                    end
                    n_cnt = r_cnt + CW'(1);
                    // length cap closes the label on this byte
                    if (n_cnt >= CW'(MAX_NAME_LEN)) begin
                        ev[0]  = 1'b1;
                        e[0]   = stc_pkg::make_out(
                            stc_pkg::label_code(n_pre, n_cnt[3:0],
                                                n_cnt <= CW'(stc_pkg::PREFIX_LEN)),
                            8'(n_cnt));
                        n_mode = MODE_IDLE;
                    end
                end else begin
                    ev[0]  = 1'b1;
                    e[0]   = stc_pkg::make_out(
                        stc_pkg::label_code(r_pre, r_cnt[3:0],
                                            r_cnt <= CW'(stc_pkg::PREFIX_LEN)),
                        8'(r_cnt));
                    n_mode = MODE_IDLE;
                    sb_use = 1'b1;
                end
            end
            MODE_MATH: begin
                n_mode = MODE_IDLE;
                ev[0]  = 1'b1;
                if (stc_pkg::is_math(b)) begin
                    if (r_pend == "=") begin
                        // '=' pairs only with '='
                        if (b == "=") begin
                            e[0] = stc_pkg::make_out(stc_pkg::CODE_EQ_EQ, 8'd2);
                        end else begin
                            e[0]   = stc_pkg::make_out(stc_pkg::CODE_EQ, 8'd1);
                            sb_use = 1'b1;
                        end
                    end else begin
                        e[0] = stc_pkg::make_out(stc_pkg::math_pair(r_pend, b), 8'd2);
                    end
                end else begin
                    e[0]   = stc_pkg::make_out(stc_pkg::math_single(r_pend), 8'd1);
                    sb_use = 1'b1;
                end
            end
            default: begin
                sb_use = 1'b1;
            end
        endcase

        // Fresh token start
        if (sb_use) begin
            n_mode = MODE_IDLE;
            ev[1]  = sb.emit;
            e[1]   = stc_pkg::make_out(sb.code, sb.len);
            if (sb.open_label) begin
                n_pre[0] = b;
                n_cnt    = CW'(1);
                n_mode   = MODE_LABEL;
            end
            if (sb.open_math) begin
                n_pend = b;
                n_mode = MODE_MATH;
            end
        end

        // End of text flushes what is pending
        if (i_item.end_of_text) begin
            if (n_mode == MODE_MATH) begin
                ev[2] = 1'b1;
                e[2]  = stc_pkg::make_out(stc_pkg::math_single(n_pend), 8'd1);
            end else if (n_mode == MODE_LABEL) begin
                ev[2] = 1'b1;
                e[2]  = stc_pkg::make_out(
                    stc_pkg::label_code(n_pre, n_cnt[3:0],
                                        n_cnt <= CW'(stc_pkg::PREFIX_LEN)),
                    8'(n_cnt));
            end
            n_mode = MODE_IDLE;
        end
    end

    // Keep the first two candidates, mark the last one kept
    always_comb begin
        o_res        = '0;
        o_res.first  = ev[0] ? e[0] : (ev[1] ? e[1] : e[2]);
        o_res.second = (ev[0] && ev[1]) ? e[1] : e[2];
        case (ev)
            3'b000:                      o_res.count = 2'd0;
            3'b001, 3'b010, 3'b100:      o_res.count = 2'd1;
            default:                     o_res.count = 2'd2;
        endcase
        if (o_res.count == 2'd1) begin
            o_res.first.last_of_run = 1'b1;
        end
        if (o_res.count == 2'd2) begin
            o_res.second.last_of_run = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_pend <= '0;
            r_cnt  <= '0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

    // Label prefix, only entries below the count are read
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_pre <= n_pre;
        end
    end

endmodule

// File: hw/rtl/script_token_classifier.sv
// Top level of the script token classifier: lexer plus result queue.
// Depends on stc_pkg and stc_lexer.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  input   | in        | i_valid / o_stall  | i_data  (stc_pkg::t_in)
//  result  | out       | o_valid / i_stall  | o_data  (stc_pkg::t_out)
//
// A byte is classified in the cycle it is accepted and its results land in a
// three-entry result queue; one result leaves per cycle while i_stall is low.
// Sustained rate is then one byte per cycle while bytes cause at most one
// result; a byte with two results holds the input off as the queue drains.
// Synchronous active-low reset empties the queue and returns the lexer to idle.
// i_stall holds the queue head; the input stalls when two or more results wait.
module script_token_classifier #(
    parameter int MAX_NAME_LEN = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  stc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output stc_pkg::t_out o_data
);

    localparam int QD = 3;

    stc_pkg::t_lex_out res;
    stc_pkg::t_out     r_q [QD];
    stc_pkg::t_out     n_q [QD];
    logic [1:0]        r_cnt, n_cnt;
    logic [1:0]        base;
    logic              take;
    logic              pop;

    assign o_stall = (r_cnt > 2'd1);
    assign take    = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_q[0];

    stc_lexer #(
        .MAX_NAME_LEN(MAX_NAME_LEN)
    ) u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_data),
        .o_res   (res)
    );

    // Queue: shift out the head, append new results behind what remains
    always_comb begin
        for (int i = 0; i < QD; i++) begin
            n_q[i] = r_q[i];
        end
        if (pop) begin
            for (int i = 0; i < QD - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        base  = r_cnt - {1'b0, pop};
        n_cnt = base;
        if (take) begin
            if (res.count != 2'd0) begin
                n_q[base] = res.first;
            end
            if (res.count == 2'd2) begin
                n_q[base + 2'd1] = res.second;
            end
            n_cnt = base + res.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QD; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule
